// File: rtl/core/plcf_pkg.sv
// Package for the profile line centre finder: shared widths, parameter defaults,
// the controller state type and the command and status structs.
// Depends on nothing; every other file of the block but plcf_ram imports it.
`timescale 1ns / 1ps

package plcf_pkg;

   localparam int ROW_W           = 12;
   localparam int POS_W           = 11;
   localparam int MAX_ROWS_DEF    = 2048;
   localparam int VALUE_WIDTH_DEF = 12;
   localparam int MAX_LINES_DEF   = 64;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_COUNT_INIT,
      ST_COUNT,
      ST_EMIT_INIT,
      ST_EMIT,
      ST_NONE,
      ST_DONE
   } plcf_state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_init;
      logic div_step;
      logic scan_init;
      logic count_pass;
      logic emit_pass;
      logic none_emit;
      logic clear;
   } plcf_cmd_type;

   typedef struct packed {
      logic div_last;
      logic scan_done;
      logic no_lines;
   } plcf_status_type;

endpackage

// File: rtl/core/plcf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the profile store.
`timescale 1ns / 1ps

module plcf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/plcf_ctrl.sv
// Controller of the profile line centre finder: sequences loading, threshold
// arithmetic, the counting pass and the reporting pass. Depends on plcf_pkg.
`timescale 1ns / 1ps

module plcf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     last_value,
   output logic                     busy,
   output plcf_pkg::plcf_cmd_type   cmd,
   input  plcf_pkg::plcf_status_type status
);
   import plcf_pkg::*;

   plcf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (start && last_value) state_in = ST_MUL;
         end
         ST_MUL:        state_in = ST_DIV_INIT;
         ST_DIV_INIT:   state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_last) state_in = ST_COUNT_INIT;
         end
         ST_COUNT_INIT: state_in = ST_COUNT;
         ST_COUNT: begin
            if (status.scan_done) state_in = ST_EMIT_INIT;
         end
         // The line total is final here, in the state after the counting pass.
         ST_EMIT_INIT: begin
            if (status.no_lines) state_in = ST_NONE;
            else                 state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.scan_done) state_in = ST_DONE;
         end
         ST_NONE:       state_in = ST_LOAD;
         ST_DONE:       state_in = ST_LOAD;
         default:       state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_MUL:        cmd.mul = 1'b1;
         ST_DIV_INIT:   cmd.div_init = 1'b1;
         ST_DIV:        cmd.div_step = 1'b1;
         ST_COUNT_INIT: cmd.scan_init = 1'b1;
         ST_COUNT:      cmd.count_pass = 1'b1;
         ST_EMIT_INIT:  cmd.scan_init = 1'b1;
         ST_EMIT:       cmd.emit_pass = 1'b1;
         ST_NONE: begin
            cmd.none_emit = 1'b1;
            cmd.clear     = 1'b1;
         end
         ST_DONE:       cmd.clear = 1'b1;
         default:       cmd = '0;
      endcase
   end

endmodule

// File: rtl/core/plcf_datapath.sv
// Datapath of the profile line centre finder: profile store, running sums,
// threshold multiply and restoring divider, run scanner and result register.
// Depends on plcf_pkg and plcf_ram.
`timescale 1ns / 1ps

module plcf_datapath #(
   parameter int MAX_ROWS    = plcf_pkg::MAX_ROWS_DEF,
   parameter int VALUE_WIDTH = plcf_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_LINES   = plcf_pkg::MAX_LINES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  plcf_pkg::plcf_cmd_type      cmd,
   output plcf_pkg::plcf_status_type   status,
   input  logic [plcf_pkg::ROW_W-1:0]  row_value,
   output logic                        rsp_strobe,
   output logic [plcf_pkg::POS_W-1:0]  rsp_line_position,
   output logic                        rsp_last_line,
   output logic                        rsp_none_found,
   output logic                        rsp_truncated
);
   import plcf_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int AW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_ROWS + 1);
   localparam int NW = VW + CW + 1;
   localparam int SW = $clog2(VW);
   localparam int LW = $clog2(MAX_LINES + 2);

   // Series accumulation.
   logic [VW+CW-1:0] sum_ff, sum_in;
   logic [VW-1:0]    least_ff, least_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [VW+ROW_W-1:0] value_ext;
   logic [VW-1:0]    value;
   logic             wr_en;

   assign value_ext = {{VW{1'b0}}, row_value};
   assign value     = value_ext[VW-1:0];
   assign wr_en     = cmd.load && (count_ff < CW'(MAX_ROWS));

   always_comb begin
      sum_in   = sum_ff;
      least_in = least_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         sum_in   = '0;
         least_in = '1;
         count_in = '0;
      end else if (wr_en) begin
         sum_in   = sum_ff + (VW+CW)'(value);
         count_in = count_ff + 1'b1;
         if (value < least_ff) least_in = value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         least_ff <= '1;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         least_ff <= least_in;
         count_ff <= count_in;
      end
   end

   // Threshold: floor((sum + least*n) / (2n)). The quotient never exceeds the
   // largest entry, so VW restoring steps suffice once the high part of the
   // numerator is preloaded as the remainder.
   logic [VW+CW-1:0] product;
   logic [NW-1:0]    numer_ff;
   logic [CW:0]      denom_ff;
   logic [CW:0]      rem_ff, rem_in;
   logic [VW-1:0]    quo_ff, quo_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [CW+1:0]    trial;
   logic [CW+1:0]    diff;
   logic             fits;

   assign product = least_ff * count_ff;
   assign trial   = {rem_ff, quo_ff[VW-1]};
   assign diff    = trial - {1'b0, denom_ff};
   assign fits    = trial >= {1'b0, denom_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      if (cmd.div_init) begin
         rem_in  = numer_ff[NW-1:VW];
         quo_in  = numer_ff[VW-1:0];
         step_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = fits ? diff[CW:0] : trial[CW:0];
         quo_in  = {quo_ff[VW-2:0], fits};
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         numer_ff <= {1'b0, sum_ff} + {1'b0, product};
         denom_ff <= {count_ff, 1'b0};
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   // Profile store.
   logic [CW-1:0] issue_ff, issue_in;
   logic [VW-1:0] rd_data;

   plcf_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (value),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // Scanner: reads one entry a cycle and evaluates it in the following cycle.
   logic          scan_run;
   logic          issue_more;
   logic          eval_valid_ff, eval_valid_in;
   logic [CW-1:0] eval_idx_ff;
   logic          in_run_ff, in_run_in;
   logic          prev_hi_ff, prev_hi_in;
   logic [AW-1:0] begin_ff, begin_in;
   logic          hi;
   logic          close;
   logic [LW-1:0] total_ff, total_in;
   logic [LW-1:0] emitted_ff, emitted_in;
   logic [LW-1:0] limit;
   logic          over;
   logic          emit;

   assign scan_run      = cmd.count_pass || cmd.emit_pass;
   assign issue_more    = issue_ff < count_ff;
   assign eval_valid_in = scan_run && issue_more;
   assign hi            = rd_data >= quo_ff;
   assign over          = total_ff > LW'(MAX_LINES);
   assign limit         = over ? LW'(MAX_LINES) : total_ff;

   always_comb begin
      issue_in = issue_ff;
      if (cmd.scan_init) issue_in = '0;
      else if (eval_valid_in) issue_in = issue_ff + 1'b1;
   end

   always_comb begin
      in_run_in  = in_run_ff;
      prev_hi_in = prev_hi_ff;
      begin_in   = begin_ff;
      close      = 1'b0;
      if (eval_valid_ff) begin
         prev_hi_in = hi;
         if (eval_idx_ff == '0) begin
            in_run_in = 1'b0;
         end else if (!in_run_ff && hi && !prev_hi_ff) begin
            in_run_in = 1'b1;
            begin_in  = eval_idx_ff[AW-1:0];
         end else if (in_run_ff && !hi) begin
            in_run_in = 1'b0;
            close     = 1'b1;
         end
      end
   end

   assign emit = cmd.emit_pass && close && (emitted_ff < limit);

   always_comb begin
      total_in   = total_ff;
      emitted_in = emitted_ff;
      if (cmd.clear) begin
         total_in   = '0;
         emitted_in = '0;
      end else begin
         if (cmd.count_pass && close && !over) total_in = total_ff + 1'b1;
         if (emit) emitted_in = emitted_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff      <= '0;
         eval_valid_ff <= 1'b0;
         in_run_ff     <= 1'b0;
         prev_hi_ff    <= 1'b0;
         begin_ff      <= '0;
         total_ff      <= '0;
         emitted_ff    <= '0;
      end else begin
         issue_ff      <= issue_in;
         eval_valid_ff <= eval_valid_in;
         in_run_ff     <= in_run_in;
         prev_hi_ff    <= prev_hi_in;
         begin_ff      <= begin_in;
         total_ff      <= total_in;
         emitted_ff    <= emitted_in;
      end
      eval_idx_ff <= issue_ff;
   end

   // Result register.
   logic [AW:0]         mid_sum;
   logic [AW+POS_W-1:0] pos_ext;
   logic                strobe_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                last_ff, none_ff, trunc_ff;

   assign mid_sum = {1'b0, begin_ff} + {1'b0, eval_idx_ff[AW-1:0]};
   assign pos_ext = {{POS_W{1'b0}}, mid_sum[AW:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= emit || cmd.none_emit;
      end
      if (cmd.none_emit) begin
         pos_ff   <= '0;
         last_ff  <= 1'b1;
         none_ff  <= 1'b1;
         trunc_ff <= 1'b0;
      end else if (emit) begin
         pos_ff   <= pos_ext[POS_W-1:0];
         last_ff  <= (emitted_ff + 1'b1) == limit;
         none_ff  <= 1'b0;
         trunc_ff <= over;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_line_position = pos_ff;
   assign rsp_last_line     = last_ff;
   assign rsp_none_found    = none_ff;
   assign rsp_truncated     = trunc_ff;

   assign status.div_last  = cmd.div_step && (step_ff == SW'(VW - 1));
   assign status.scan_done = eval_valid_ff && ((eval_idx_ff + 1'b1) == count_ff);
   assign status.no_lines  = total_ff == '0;

endmodule

// File: rtl/core/profile_line_center_finder.sv
// Profile line centre finder. Histogram beats load at one per cycle while busy is low.
// After the last beat busy stays high through the threshold arithmetic (multiply,
// divider load, one divider step per value bit), then through a counting pass and a
// reporting pass over the stored entries and a clearing step; the reporting pass is
// skipped when no line is found. Results are registered, and the receiver cannot stall.
// Synchronous reset clears the series; the store keeps its contents.
`timescale 1ns / 1ps

module profile_line_center_finder #(
   parameter int MAX_ROWS    = plcf_pkg::MAX_ROWS_DEF,
   parameter int VALUE_WIDTH = plcf_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_LINES   = plcf_pkg::MAX_LINES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [plcf_pkg::ROW_W-1:0]  req_row_value,
   input  logic                        req_last_value,
   output logic                        rsp_strobe,
   output logic [plcf_pkg::POS_W-1:0]  rsp_line_position,
   output logic                        rsp_last_line,
   output logic                        rsp_none_found,
   output logic                        rsp_truncated
);
   import plcf_pkg::*;

   plcf_cmd_type    cmd;
   plcf_status_type status;

   plcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_value (req_last_value),
      .busy       (busy),
      .cmd        (cmd),
      .status     (status)
   );

   plcf_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_LINES   (MAX_LINES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .row_value         (req_row_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_line_position (rsp_line_position),
      .rsp_last_line     (rsp_last_line),
      .rsp_none_found    (rsp_none_found),
      .rsp_truncated     (rsp_truncated)
   );

endmodule

// File: rtl/core/plcf_checker.sv
// Port-level checker for the profile line centre finder and its bind.
// Depends on plcf_pkg and the top level profile_line_center_finder.
`timescale 1ns / 1ps

module plcf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_last_value,
   input logic                        rsp_strobe,
   input logic [plcf_pkg::POS_W-1:0]  rsp_line_position,
   input logic                        rsp_last_line,
   input logic                        rsp_none_found,
   input logic                        rsp_truncated
);
   import plcf_pkg::*;

   // A closing beat starts the processing of the series.
   a_last_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_value |=> busy)
      else $error("busy not raised after the closing beat");

   // Results only come out of processing.
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without preceding processing");

   a_none_form: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_none_found |->
         rsp_last_line && (rsp_line_position == '0) && !rsp_truncated)
      else $error("malformed no-line result");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_line |=> !rsp_strobe)
      else $error("result beat straight after the final result");

endmodule

bind profile_line_center_finder plcf_checker u_plcf_checker (.*);

// File: dv/profile_line_center_finder_tb.sv
// Self-checking testbench for the profile line centre finder. Histogram beats are sent
// through the start/busy handshake, and a local predictor works out the line centres.
// Depends on plcf_pkg and the profile_line_center_finder top level.
`timescale 1ns / 1ps

module profile_line_center_finder_tb;
   import plcf_pkg::*;

   localparam int MAX_ROWS     = MAX_ROWS_DEF;
   localparam int MAX_LINES    = MAX_LINES_DEF;
   localparam int QUIET_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [ROW_W-1:0] TOP_VALUE = '1;
   localparam logic [ROW_W-1:0] LOW_VALUE = '0;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             last_line;
      logic             none_found;
      logic             truncated;
   } line_centre_type;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             start          = 1'b0;
   logic [ROW_W-1:0] req_row_value  = '0;
   logic             req_last_value = 1'b0;
   logic             busy;
   logic             rsp_strobe;
   logic [POS_W-1:0] rsp_line_position;
   logic             rsp_last_line;
   logic             rsp_none_found;
   logic             rsp_truncated;

   line_centre_type   expected_centres[$];
   logic [ROW_W-1:0]  profile_beats[$];
   logic [ROW_W-1:0]  row_copy[MAX_ROWS];
   longint unsigned   row_total = 0;
   longint unsigned   row_least = TOP_VALUE;
   int unsigned       rows_held = 0;

   int sender_idle_pct  = 11;
   int errors           = 0;
   int beats_sent       = 0;
   int series_sent      = 0;
   int centres_seen     = 0;
   int truncated_series = 0;
   int quiet_cycles     = 0;

   always #5 clock = ~clock;

   profile_line_center_finder i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_row_value     (req_row_value),
      .req_last_value    (req_last_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_line_position (rsp_line_position),
      .rsp_last_line     (rsp_last_line),
      .rsp_none_found    (rsp_none_found),
      .rsp_truncated     (rsp_truncated)
   );

   // Stores one histogram beat; on the last beat works out the threshold and the
   // centres of the closed runs up to the result limit, then clears the series.
   task automatic predict_centres(input logic [ROW_W-1:0] value, input logic last);
      line_centre_type found[$];
      line_centre_type item;
      longint unsigned level;
      int unsigned     run_start;
      logic            open;
      logic            above;
      logic            above_prev;
      logic            cut;
      run_start = 0;
      open      = 1'b0;
      cut       = 1'b0;
      if (rows_held < MAX_ROWS) begin
         row_copy[rows_held] = value;
         rows_held++;
         row_total += value;
         if (value < row_least) row_least = value;
      end
      if (!last) return;
      if (rows_held >= 2) begin
         level = (row_total + row_least * rows_held) / (2 * rows_held);
         for (int unsigned i = 1; i < rows_held; i++) begin
            above      = row_copy[i] >= level;
            above_prev = row_copy[i-1] >= level;
            if (!open && above && !above_prev) begin
               open      = 1'b1;
               run_start = i;
            end else if (open && !above) begin
               open = 1'b0;
               if (found.size() < MAX_LINES) begin
                  item          = '0;
                  item.position = POS_W'((run_start + i) / 2);
                  found         = {found, item};
               end else begin
                  cut = 1'b1;
               end
            end
         end
      end
      if (found.size() == 0) begin
         item            = '0;
         item.last_line  = 1'b1;
         item.none_found = 1'b1;
         found           = {found, item};
      end else begin
         foreach (found[k]) found[k].truncated = cut;
         found[found.size()-1].last_line = 1'b1;
      end
      if (cut) truncated_series++;
      expected_centres = {expected_centres, found};
      series_sent++;
      row_total = 0;
      row_least = TOP_VALUE;
      rows_held = 0;
   endtask

   // Start is only lowered when a gap is taken, so it never sees two updates in one step.
   task automatic send_row(input logic [ROW_W-1:0] value, input logic last);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_row_value  <= value;
      req_last_value <= last;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_centres(value, last);
      beats_sent++;
   endtask

   task automatic send_profile();
      foreach (profile_beats[i]) send_row(profile_beats[i], i == profile_beats.size() - 1);
   endtask

   // Alternating dark and light bands of random length, with a little noise mixed in.
   task automatic build_banded(input int rows, input int band_max);
      int   lo_top;
      int   hi_floor;
      int   seg;
      logic high;
      profile_beats.delete();
      lo_top   = $urandom_range(1800, 0);
      hi_floor = $urandom_range(TOP_VALUE, 2200);
      high     = 1'($urandom_range(1, 0));
      while (profile_beats.size() < rows) begin
         seg = $urandom_range(band_max, 1);
         repeat (seg) begin
            if (profile_beats.size() < rows) begin
               if ($urandom_range(99) < 4)
                  profile_beats = {profile_beats, ROW_W'($urandom_range(TOP_VALUE, 0))};
               else if (high)
                  profile_beats = {profile_beats,
                                   ROW_W'($urandom_range(TOP_VALUE, hi_floor))};
               else
                  profile_beats = {profile_beats, ROW_W'($urandom_range(lo_top, 0))};
            end
         end
         high = !high;
      end
   endtask

   task automatic directed_test();
      profile_beats = '{TOP_VALUE};
      send_profile();
      // A run that starts at the last entry is still open at the end.
      profile_beats = '{LOW_VALUE, TOP_VALUE};
      send_profile();
      // A run already high at the first entry never begins.
      profile_beats = '{TOP_VALUE, TOP_VALUE, LOW_VALUE, LOW_VALUE};
      send_profile();
      profile_beats = '{LOW_VALUE, TOP_VALUE, TOP_VALUE, LOW_VALUE};
      send_profile();
      profile_beats = '{12'd7, 12'd7, 12'd7};
      send_profile();
      profile_beats = '{LOW_VALUE, LOW_VALUE, LOW_VALUE};
      send_profile();
      profile_beats = '{12'd1, 12'd2048, 12'd1, 12'd2048, 12'd1};
      send_profile();
   endtask

   // One line more than the result limit, so the series is reported as truncated.
   task automatic truncation_test();
      profile_beats = '{LOW_VALUE};
      repeat (MAX_LINES + 1) profile_beats = {profile_beats, TOP_VALUE, LOW_VALUE};
      send_profile();
   endtask

   task automatic random_series_test(input int budget);
      int goal;
      goal = beats_sent + budget;
      while (beats_sent < goal) begin
         case ($urandom_range(19))
            0, 1:    build_banded($urandom_range(3, 1), 1);
            2:       build_banded($urandom_range(150, 70), 1);
            default: build_banded($urandom_range(40, 4), $urandom_range(8, 1));
         endcase
         send_profile();
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      line_centre_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= ((start && !busy) || rsp_strobe) ? 0 : quiet_cycles + 1;
         if (rsp_strobe) begin
            centres_seen++;
            if (expected_centres.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual position %0d last %0b",
                        $time, rsp_line_position, rsp_last_line);
            end else begin
               want = expected_centres.pop_front();
               compare_field("line_position", want.position, rsp_line_position);
               compare_field("last_line", want.last_line, rsp_last_line);
               compare_field("none_found", want.none_found, rsp_none_found);
               compare_field("truncated", want.truncated, rsp_truncated);
            end
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL profile_line_center_finder");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 11;
      directed_test();
      random_series_test(60);
      sender_idle_pct = 78;
      truncation_test();
      random_series_test(60);
      sender_idle_pct = 0;
      random_series_test(60);
      start <= 1'b0;
      while (expected_centres.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d histogram beats in %0d series, checked %0d line results.",
               beats_sent, series_sent, centres_seen);
      $display("Covered %0d truncated series, short and flat series and three sender gap rates.",
               truncated_series);
      if (errors == 0)
         $display("PASS profile_line_center_finder");
      else
         $display("FAIL profile_line_center_finder");
      $finish;
   end

endmodule
